// ----- hw/rtl/sor_pkg.sv -----
package sor_pkg;

   // Input and result words
   typedef struct packed {
      logic signed [23:0] x_in;
      logic signed [23:0] y_in;
      logic signed [23:0] z_in;
   } req_type;

   typedef struct packed {
      logic signed [23:0] x_out;
      logic signed [23:0] y_out;
      logic signed [23:0] z_out;
      logic               clipped;
   } rsp_type;

   // Q1.17 coefficient, one 3x3 matrix and its nine products
   typedef logic signed [18:0] coef_type;
   typedef coef_type [8:0] coef_mat_type;
   typedef logic signed [42:0] prod_type;
   typedef prod_type [8:0] prod_vec_type;

   localparam int FracBits = 17;

   localparam coef_type CA = 19'sd131072;
   localparam coef_type CH = 19'sd92682;
   localparam coef_type CS = 19'sd15974;
   localparam coef_type CC = 19'sd130095;

   localparam logic signed [23:0] MaxVal = 24'sh7FFFFF;
   localparam logic signed [23:0] MinVal = -24'sh800000;

   // Board orientation codes; codes beyond the list pass through
   typedef enum logic [5:0] {
      ROT_NONE                      = 6'd0,
      ROT_YAW_45                    = 6'd1,
      ROT_YAW_90                    = 6'd2,
      ROT_YAW_135                   = 6'd3,
      ROT_YAW_180                   = 6'd4,
      ROT_YAW_225                   = 6'd5,
      ROT_YAW_270                   = 6'd6,
      ROT_YAW_315                   = 6'd7,
      ROT_ROLL_180                  = 6'd8,
      ROT_ROLL_180_YAW_45           = 6'd9,
      ROT_ROLL_180_YAW_90           = 6'd10,
      ROT_ROLL_180_YAW_135          = 6'd11,
      ROT_PITCH_180                 = 6'd12,
      ROT_ROLL_180_YAW_225          = 6'd13,
      ROT_ROLL_180_YAW_270          = 6'd14,
      ROT_ROLL_180_YAW_315          = 6'd15,
      ROT_ROLL_90                   = 6'd16,
      ROT_ROLL_90_YAW_45            = 6'd17,
      ROT_ROLL_90_YAW_90            = 6'd18,
      ROT_ROLL_90_YAW_135           = 6'd19,
      ROT_ROLL_270                  = 6'd20,
      ROT_ROLL_270_YAW_45           = 6'd21,
      ROT_ROLL_270_YAW_90           = 6'd22,
      ROT_ROLL_270_YAW_135          = 6'd23,
      ROT_PITCH_90                  = 6'd24,
      ROT_PITCH_270                 = 6'd25,
      ROT_PITCH_180_YAW_90          = 6'd26,
      ROT_PITCH_180_YAW_270         = 6'd27,
      ROT_ROLL_90_PITCH_90          = 6'd28,
      ROT_ROLL_180_PITCH_90         = 6'd29,
      ROT_ROLL_270_PITCH_90         = 6'd30,
      ROT_ROLL_90_PITCH_180         = 6'd31,
      ROT_ROLL_270_PITCH_180        = 6'd32,
      ROT_ROLL_90_PITCH_270         = 6'd33,
      ROT_ROLL_180_PITCH_270        = 6'd34,
      ROT_ROLL_270_PITCH_270        = 6'd35,
      ROT_ROLL_90_PITCH_180_YAW_90  = 6'd36,
      ROT_ROLL_90_YAW_270           = 6'd37,
      ROT_ROLL_90_PITCH_68_YAW_293  = 6'd38,
      ROT_PITCH_315                 = 6'd39,
      ROT_ROLL_90_PITCH_315         = 6'd40,
      ROT_PITCH_7                   = 6'd41,
      ROT_ROLL_45                   = 6'd42,
      ROT_ROLL_315                  = 6'd43
   } orient_type;

   // Pack a matrix given row by row
   function automatic coef_mat_type make_mat(
      input coef_type m00, input coef_type m01, input coef_type m02,
      input coef_type m10, input coef_type m11, input coef_type m12,
      input coef_type m20, input coef_type m21, input coef_type m22);
      coef_mat_type m;
      m[0] = m00; m[1] = m01; m[2] = m02;
      m[3] = m10; m[4] = m11; m[5] = m12;
      m[6] = m20; m[7] = m21; m[8] = m22;
      return m;
   endfunction

   // Rotation matrix for each orientation code, entry [3*row+col]
   function automatic coef_mat_type orient_matrix(input logic [5:0] code);
      coef_mat_type m;
      case (orient_type'(code))
         ROT_YAW_45:           m = make_mat(CH, -CH, 0,  CH, CH, 0,   0, 0, CA);
         ROT_YAW_90:           m = make_mat(0, -CA, 0,   CA, 0, 0,    0, 0, CA);
         ROT_YAW_135:          m = make_mat(-CH, -CH, 0, CH, -CH, 0,  0, 0, CA);
         ROT_YAW_180:          m = make_mat(-CA, 0, 0,   0, -CA, 0,   0, 0, CA);
         ROT_YAW_225:          m = make_mat(-CH, CH, 0,  -CH, -CH, 0, 0, 0, CA);
         ROT_YAW_270:          m = make_mat(0, CA, 0,    -CA, 0, 0,   0, 0, CA);
         ROT_YAW_315:          m = make_mat(CH, CH, 0,   -CH, CH, 0,  0, 0, CA);
         ROT_ROLL_180:         m = make_mat(CA, 0, 0,    0, -CA, 0,   0, 0, -CA);
         ROT_ROLL_180_YAW_45:  m = make_mat(CH, CH, 0,   CH, -CH, 0,  0, 0, -CA);
         ROT_ROLL_180_YAW_90,
         ROT_PITCH_180_YAW_270:
                               m = make_mat(0, CA, 0,    CA, 0, 0,    0, 0, -CA);
         ROT_ROLL_180_YAW_135: m = make_mat(-CH, CH, 0,  CH, CH, 0,   0, 0, -CA);
         ROT_PITCH_180:        m = make_mat(-CA, 0, 0,   0, CA, 0,    0, 0, -CA);
         ROT_ROLL_180_YAW_225: m = make_mat(-CH, -CH, 0, -CH, CH, 0,  0, 0, -CA);
         ROT_ROLL_180_YAW_270,
         ROT_PITCH_180_YAW_90:
                               m = make_mat(0, -CA, 0,   -CA, 0, 0,   0, 0, -CA);
         ROT_ROLL_180_YAW_315: m = make_mat(CH, -CH, 0,  -CH, -CH, 0, 0, 0, -CA);
         ROT_ROLL_90:          m = make_mat(CA, 0, 0,    0, 0, -CA,   0, CA, 0);
         ROT_ROLL_90_YAW_45:   m = make_mat(CH, 0, CH,   CH, 0, -CH,  0, CA, 0);
         ROT_ROLL_90_YAW_90:   m = make_mat(0, 0, CA,    CA, 0, 0,    0, CA, 0);
         ROT_ROLL_90_YAW_135:  m = make_mat(-CH, 0, CH,  CH, 0, CH,   0, CA, 0);
         ROT_ROLL_270:         m = make_mat(CA, 0, 0,    0, 0, CA,    0, -CA, 0);
         ROT_ROLL_270_YAW_45:  m = make_mat(CH, 0, -CH,  CH, 0, CH,   0, -CA, 0);
         ROT_ROLL_270_YAW_90:  m = make_mat(0, 0, -CA,   CA, 0, 0,    0, -CA, 0);
         ROT_ROLL_270_YAW_135: m = make_mat(-CH, 0, -CH, CH, 0, -CH,  0, -CA, 0);
         ROT_PITCH_90:         m = make_mat(0, 0, CA,    0, CA, 0,    -CA, 0, 0);
         ROT_PITCH_270:        m = make_mat(0, 0, -CA,   0, CA, 0,    CA, 0, 0);
         ROT_ROLL_90_PITCH_90: m = make_mat(0, CA, 0,    0, 0, -CA,   -CA, 0, 0);
         ROT_ROLL_180_PITCH_90:
                               m = make_mat(0, 0, -CA,   0, -CA, 0,   -CA, 0, 0);
         ROT_ROLL_270_PITCH_90:
                               m = make_mat(0, -CA, 0,   0, 0, CA,    -CA, 0, 0);
         ROT_ROLL_90_PITCH_180:
                               m = make_mat(-CA, 0, 0,   0, 0, -CA,   0, -CA, 0);
         ROT_ROLL_270_PITCH_180:
                               m = make_mat(-CA, 0, 0,   0, 0, CA,    0, CA, 0);
         ROT_ROLL_90_PITCH_270:
                               m = make_mat(0, -CA, 0,   0, 0, -CA,   CA, 0, 0);
         ROT_ROLL_180_PITCH_270:
                               m = make_mat(0, 0, CA,    0, -CA, 0,   CA, 0, 0);
         ROT_ROLL_270_PITCH_270:
                               m = make_mat(0, CA, 0,    0, 0, CA,    CA, 0, 0);
         ROT_ROLL_90_PITCH_180_YAW_90:
                               m = make_mat(0, 0, CA,    -CA, 0, 0,   0, -CA, 0);
         ROT_ROLL_90_YAW_270:  m = make_mat(0, 0, -CA,   -CA, 0, 0,   0, CA, 0);
         ROT_ROLL_90_PITCH_68_YAW_293:
            m = make_mat(19'sd18748, 19'sd48336, -19'sd120383,
                         -19'sd43533, -19'sd112236, -19'sd51845,
                         -19'sd122202, 19'sd47399, 0);
         ROT_PITCH_315:        m = make_mat(CH, 0, -CH,  0, CA, 0,    CH, 0, CH);
         ROT_ROLL_90_PITCH_315:
                               m = make_mat(CH, -CH, 0,  0, 0, -CA,   CH, CH, 0);
         ROT_PITCH_7:          m = make_mat(CC, 0, CS,   0, CA, 0,    -CS, 0, CC);
         ROT_ROLL_45:          m = make_mat(CA, 0, 0,    0, CH, -CH,  0, CH, CH);
         ROT_ROLL_315:         m = make_mat(CA, 0, 0,    0, CH, CH,   0, -CH, CH);
         default:              m = make_mat(CA, 0, 0,    0, CA, 0,    0, 0, CA);
      endcase
      return m;
   endfunction

endpackage

// ----- hw/rtl/sor_mult.sv -----
module sor_mult (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  sor_pkg::req_type      req_data,
   input  sor_pkg::coef_mat_type coef,
   output logic                  prod_valid,
   output sor_pkg::prod_vec_type prod
);
   import sor_pkg::*;

   logic                     in_valid_ff;
   req_type                  in_word_ff;
   logic                     prod_valid_ff;
   prod_vec_type             prod_ff;
   prod_vec_type             prod_in;
   logic signed [2:0][23:0]  vec;

   // Hold the accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= load;
      end
      if (load) begin
         in_word_ff <= req_data;
      end
   end

   assign vec[0] = in_word_ff.x_in;
   assign vec[1] = in_word_ff.y_in;
   assign vec[2] = in_word_ff.z_in;

   // Form all nine coefficient products
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[3*r+c] = $signed(coef[3*r+c]) * $signed(vec[c]);
         end
      end
   end

   // Advance the products
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= in_valid_ff;
      end
      prod_ff <= prod_in;
   end

   assign prod_valid = prod_valid_ff;
   assign prod       = prod_ff;

endmodule

// ----- hw/rtl/sor_finish.sv -----
module sor_finish (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  prod_valid,
   input  sor_pkg::prod_vec_type prod,
   output logic                  rsp_valid,
   output sor_pkg::rsp_type      rsp_data
);
   import sor_pkg::*;

   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;
   logic signed [2:0][23:0] comp;
   logic [2:0]              sat;

   // Sum each row, round half up, saturate to 24 bits
   always_comb begin
      logic signed [45:0] sum;
      logic signed [28:0] q;
      for (int r = 0; r < 3; r++) begin
         sum = {{3{prod[3*r][42]}},   prod[3*r]}
             + {{3{prod[3*r+1][42]}}, prod[3*r+1]}
             + {{3{prod[3*r+2][42]}}, prod[3*r+2]}
             + 46'sd65536;
         q = sum[45:FracBits];
         if (q > 29'(MaxVal)) begin
            comp[r] = MaxVal;
            sat[r]  = 1'b1;
         end else if (q < 29'(MinVal)) begin
            comp[r] = MinVal;
            sat[r]  = 1'b1;
         end else begin
            comp[r] = q[23:0];
            sat[r]  = 1'b0;
         end
      end
      rsp_in.x_out   = comp[0];
      rsp_in.y_out   = comp[1];
      rsp_in.z_out   = comp[2];
      rsp_in.clipped = |sat;
   end

   // Hold the result word for its one strobe cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= prod_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hw/rtl/sensor_orientation_rotate_unit.sv -----
// Path: a taken word passes through the input, product and result registers and then
// shows on the result ports, where the receiver takes it.
// Throughput: one word per cycle; busy stays low, as the three register stages
// (input, product, result) each take a new word every cycle.
// Reset: synchronous, active high; clears the stage valids and sets orientation to none.
// The receiver cannot stall: each result holds for exactly one cycle under rsp_valid.
module sensor_orientation_rotate_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sor_pkg::req_type req_data,
   output logic             rsp_valid,
   output sor_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [5:0]       csr_wdata
);
   import sor_pkg::*;

   logic [5:0]   orient_ff;
   coef_mat_type coef_ff;
   prod_vec_type prod;
   logic         prod_valid;
   logic         load;

   // Hold the orientation register
   always_ff @(posedge clock) begin
      if (reset) begin
         orient_ff <= ROT_NONE;
      end else if (csr_we) begin
         orient_ff <= csr_wdata;
      end
   end

   // Look the matrix up once per cycle from the register
   always_ff @(posedge clock) begin
      coef_ff <= orient_matrix(orient_ff);
   end

   assign busy = 1'b0;
   assign load = start & ~busy;

   sor_mult u_mult (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .req_data   (req_data),
      .coef       (coef_ff),
      .prod_valid (prod_valid),
      .prod       (prod)
   );

   sor_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .prod_valid (prod_valid),
      .prod       (prod),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- tb/tb_sensor_orientation_rotate_unit.sv -----
module tb_sensor_orientation_rotate_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import sor_pkg::*;

   // Codes past the orientation list pass the word through
   localparam logic [5:0] CodeFirstCustom = 6'd44;
   localparam logic [5:0] CodeLast        = 6'd63;

   // Q1.17 constants and the half-unit added before the final shift
   localparam longint QOne      = 131072;
   localparam longint QHalfRoot = 92682;
   localparam longint QSin7     = 15974;
   localparam longint QCos7     = 130095;
   localparam longint QRound    = 65536;

   localparam int ResetCycles = 8;
   localparam int DrainCycles = 8;
   localparam int StallLimit  = 2000;
   localparam int NumRows     = 25;
   localparam int NumPhases   = 66;

   typedef struct {
      logic [5:0] code;
      req_type    word;
      bit         pinned;
      rsp_type    want;
   } stim_row_type;

   logic    clock;
   logic    reset       = 1'b1;
   logic    start       = 1'b0;
   logic    busy;
   req_type req_data    = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_we      = 1'b0;
   logic [5:0] csr_wdata = '0;

   // Result typed into the table travels alongside the word it belongs to
   bit      pinned_valid = 1'b0;
   rsp_type pinned_rsp   = '0;

   rsp_type    pending_rotations[$];
   logic [5:0] active_code;
   logic [5:0] loaded_code  = ROT_NONE;
   int         mismatch_count = 0;
   int         stall_cycles   = 0;

   // Directed words: extremes, saturation on negation, aliased codes, custom codes
   stim_row_type stim_rows [NumRows] = '{
      '{ROT_NONE, '{24'sd1, 24'sd2, 24'sd3}, 1'b1, '{24'sd1, 24'sd2, 24'sd3, 1'b0}},
      '{ROT_NONE, '{MaxVal, MinVal, 24'sd0}, 1'b1, '{MaxVal, MinVal, 24'sd0, 1'b0}},
      '{ROT_NONE, '{-24'sd1, 24'sh555555, -24'sh555556}, 1'b1,
        '{-24'sd1, 24'sh555555, -24'sh555556, 1'b0}},
      '{ROT_YAW_90, '{MinVal, MaxVal, 24'sd5}, 1'b1, '{-MaxVal, MinVal, 24'sd5, 1'b0}},
      '{ROT_YAW_90, '{24'sd0, MinVal, 24'sd0}, 1'b1, '{MaxVal, 24'sd0, 24'sd0, 1'b1}},
      '{ROT_YAW_180, '{MinVal, MaxVal, MinVal}, 1'b1, '{MaxVal, -MaxVal, MinVal, 1'b1}},
      '{ROT_ROLL_180, '{MinVal, MinVal, MinVal}, 1'b1, '{MinVal, MaxVal, MaxVal, 1'b1}},
      '{ROT_PITCH_180, '{MaxVal, MaxVal, MaxVal}, 1'b1, '{-MaxVal, MaxVal, -MaxVal, 1'b0}},
      '{ROT_YAW_45, '{MaxVal, MinVal, 24'sd0}, 1'b0, '0},
      '{ROT_YAW_45, '{MaxVal, MaxVal, MaxVal}, 1'b0, '0},
      '{ROT_YAW_45, '{24'sd1, 24'sd0, 24'sd0}, 1'b0, '0},
      '{ROT_YAW_225, '{24'sd1, 24'sd1, -24'sd1}, 1'b0, '0},
      '{ROT_ROLL_90_PITCH_68_YAW_293, '{MaxVal, MinVal, MaxVal}, 1'b0, '0},
      '{ROT_ROLL_90_PITCH_68_YAW_293, '{MinVal, MaxVal, MinVal}, 1'b0, '0},
      '{ROT_PITCH_7, '{MaxVal, 24'sd0, MaxVal}, 1'b0, '0},
      '{ROT_PITCH_7, '{MinVal, -24'sd1, MinVal}, 1'b0, '0},
      '{ROT_ROLL_45, '{24'sd0, MaxVal, MaxVal}, 1'b0, '0},
      '{ROT_ROLL_315, '{24'sd0, MinVal, MaxVal}, 1'b0, '0},
      '{ROT_PITCH_315, '{MinVal, 24'sd0, MinVal}, 1'b0, '0},
      '{ROT_ROLL_90_PITCH_315, '{-24'sd1, -24'sd1, -24'sd1}, 1'b0, '0},
      '{CodeFirstCustom, '{MinVal, MaxVal, -24'sd1}, 1'b1, '{MinVal, MaxVal, -24'sd1, 1'b0}},
      '{CodeLast, '{MaxVal, MinVal, 24'sd0}, 1'b1, '{MaxVal, MinVal, 24'sd0, 1'b0}},
      '{ROT_PITCH_180_YAW_90, '{24'sd3, -24'sd7, MinVal}, 1'b1,
        '{24'sd7, -24'sd3, MaxVal, 1'b1}},
      '{ROT_PITCH_180_YAW_270, '{24'sd3, -24'sd7, 24'sd9}, 1'b1,
        '{-24'sd7, 24'sd3, -24'sd9, 1'b0}},
      '{ROT_ROLL_90, '{24'sd1, 24'sd2, MinVal}, 1'b1, '{24'sd1, MaxVal, 24'sd2, 1'b1}}
   };

   sensor_orientation_rotate_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Round half up, then saturate to 24 bits and note any clipping
   function automatic logic signed [23:0] round_sat(input longint p, inout bit clip);
      longint q;
      q = (p + QRound) >>> 17;
      if (q > longint'(MaxVal)) begin
         q = longint'(MaxVal);
         clip = 1'b1;
      end
      if (q < longint'(MinVal)) begin
         q = longint'(MinVal);
         clip = 1'b1;
      end
      return q[23:0];
   endfunction

   // Rotate one word by the orientation code held in the register
   function automatic rsp_type rotate_word(input logic [5:0] code, input req_type w);
      longint  x, y, z, t, nx, ny, nz;
      bit      mixed;
      bit      clip;
      rsp_type r;
      x = longint'(signed'(w.x_in));
      y = longint'(signed'(w.y_in));
      z = longint'(signed'(w.z_in));
      nx = 0;
      ny = 0;
      nz = 0;
      mixed = 1'b0;
      clip = 1'b0;
      case (code)
         ROT_YAW_45: begin
            nx = QHalfRoot * (x - y); ny = QHalfRoot * (x + y); nz = z * QOne; mixed = 1'b1;
         end
         ROT_YAW_90: begin
            t = x; x = -y; y = t;
         end
         ROT_YAW_135: begin
            nx = -QHalfRoot * (x + y); ny = QHalfRoot * (x - y); nz = z * QOne; mixed = 1'b1;
         end
         ROT_YAW_180: begin
            x = -x; y = -y;
         end
         ROT_YAW_225: begin
            nx = QHalfRoot * (y - x); ny = -QHalfRoot * (x + y); nz = z * QOne; mixed = 1'b1;
         end
         ROT_YAW_270: begin
            t = x; x = y; y = -t;
         end
         ROT_YAW_315: begin
            nx = QHalfRoot * (x + y); ny = QHalfRoot * (y - x); nz = z * QOne; mixed = 1'b1;
         end
         ROT_ROLL_180: begin
            y = -y; z = -z;
         end
         ROT_ROLL_180_YAW_45: begin
            nx = QHalfRoot * (x + y); ny = QHalfRoot * (x - y); nz = -z * QOne; mixed = 1'b1;
         end
         ROT_ROLL_180_YAW_90, ROT_PITCH_180_YAW_270: begin
            t = x; x = y; y = t; z = -z;
         end
         ROT_ROLL_180_YAW_135: begin
            nx = QHalfRoot * (y - x); ny = QHalfRoot * (y + x); nz = -z * QOne; mixed = 1'b1;
         end
         ROT_PITCH_180: begin
            x = -x; z = -z;
         end
         ROT_ROLL_180_YAW_225: begin
            nx = -QHalfRoot * (x + y); ny = QHalfRoot * (y - x); nz = -z * QOne;
            mixed = 1'b1;
         end
         ROT_ROLL_180_YAW_270, ROT_PITCH_180_YAW_90: begin
            t = x; x = -y; y = -t; z = -z;
         end
         ROT_ROLL_180_YAW_315: begin
            nx = QHalfRoot * (x - y); ny = -QHalfRoot * (x + y); nz = -z * QOne;
            mixed = 1'b1;
         end
         ROT_ROLL_90: begin
            t = z; z = y; y = -t;
         end
         ROT_ROLL_90_YAW_45: begin
            t = z; z = y; y = -t;
            nx = QHalfRoot * (x - y); ny = QHalfRoot * (x + y); nz = z * QOne; mixed = 1'b1;
         end
         ROT_ROLL_90_YAW_90: begin
            t = z; z = y; y = -t; t = x; x = -y; y = t;
         end
         ROT_ROLL_90_YAW_135: begin
            t = z; z = y; y = -t;
            nx = -QHalfRoot * (x + y); ny = QHalfRoot * (x - y); nz = z * QOne; mixed = 1'b1;
         end
         ROT_ROLL_270: begin
            t = z; z = -y; y = t;
         end
         ROT_ROLL_270_YAW_45: begin
            t = z; z = -y; y = t;
            nx = QHalfRoot * (x - y); ny = QHalfRoot * (x + y); nz = z * QOne; mixed = 1'b1;
         end
         ROT_ROLL_270_YAW_90: begin
            t = z; z = -y; y = t; t = x; x = -y; y = t;
         end
         ROT_ROLL_270_YAW_135: begin
            t = z; z = -y; y = t;
            nx = -QHalfRoot * (x + y); ny = QHalfRoot * (x - y); nz = z * QOne; mixed = 1'b1;
         end
         ROT_PITCH_90: begin
            t = z; z = -x; x = t;
         end
         ROT_PITCH_270: begin
            t = z; z = x; x = -t;
         end
         ROT_ROLL_90_PITCH_90: begin
            t = z; z = y; y = -t; t = z; z = -x; x = t;
         end
         ROT_ROLL_180_PITCH_90: begin
            y = -y; z = -z; t = z; z = -x; x = t;
         end
         ROT_ROLL_270_PITCH_90: begin
            t = z; z = -y; y = t; t = z; z = -x; x = t;
         end
         ROT_ROLL_90_PITCH_180: begin
            t = z; z = y; y = -t; x = -x; z = -z;
         end
         ROT_ROLL_270_PITCH_180: begin
            t = z; z = -y; y = t; x = -x; z = -z;
         end
         ROT_ROLL_90_PITCH_270: begin
            t = z; z = y; y = -t; t = z; z = x; x = -t;
         end
         ROT_ROLL_180_PITCH_270: begin
            y = -y; z = -z; t = z; z = x; x = -t;
         end
         ROT_ROLL_270_PITCH_270: begin
            t = z; z = -y; y = t; t = z; z = x; x = -t;
         end
         ROT_ROLL_90_PITCH_180_YAW_90: begin
            t = z; z = y; y = -t; x = -x; z = -z; t = x; x = -y; y = t;
         end
         ROT_ROLL_90_YAW_270: begin
            t = z; z = y; y = -t; t = x; x = y; y = -t;
         end
         ROT_ROLL_90_PITCH_68_YAW_293: begin
            nx = 18748 * x + 48336 * y - 120383 * z;
            ny = -43533 * x - 112236 * y - 51845 * z;
            nz = -122202 * x + 47399 * y;
            mixed = 1'b1;
         end
         ROT_PITCH_315: begin
            nx = QHalfRoot * (x - z); nz = QHalfRoot * (x + z); ny = y * QOne; mixed = 1'b1;
         end
         ROT_ROLL_90_PITCH_315: begin
            t = z; z = y; y = -t;
            nx = QHalfRoot * (x - z); nz = QHalfRoot * (x + z); ny = y * QOne; mixed = 1'b1;
         end
         ROT_PITCH_7: begin
            nx = QCos7 * x + QSin7 * z;
            nz = -QSin7 * x + QCos7 * z;
            ny = y * QOne;
            mixed = 1'b1;
         end
         ROT_ROLL_45: begin
            ny = QHalfRoot * (y - z); nz = QHalfRoot * (y + z); nx = x * QOne; mixed = 1'b1;
         end
         ROT_ROLL_315: begin
            ny = QHalfRoot * (y + z); nz = QHalfRoot * (z - y); nx = x * QOne; mixed = 1'b1;
         end
         default: begin
         end
      endcase
      // Swaps and flips only: scale up so rounding and saturation treat them alike
      if (!mixed) begin
         nx = x * QOne;
         ny = y * QOne;
         nz = z * QOne;
      end
      r.x_out   = round_sat(nx, clip);
      r.y_out   = round_sat(ny, clip);
      r.z_out   = round_sat(nz, clip);
      r.clipped = clip;
      return r;
   endfunction

   // Mostly full-range values, with extremes and values near zero mixed in
   function automatic logic signed [23:0] random_component();
      case ($urandom_range(0, 7))
         0:       return MaxVal;
         1:       return MinVal;
         2:       return 24'(int'($urandom_range(0, 16)) - 8);
         default: return 24'($urandom);
      endcase
   endfunction

   // Hold until every predicted word has come back
   task automatic wait_drained();
      @(posedge clock);
      while (pending_rotations.size() != 0)
         @(posedge clock);
   endtask

   // Drop start, drain, then write the orientation register
   task automatic load_orientation(input logic [5:0] code);
      start <= 1'b0;
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= code;
      @(posedge clock);
      csr_we      <= 1'b0;
      loaded_code  = code;
   endtask

   // Offer one word after a random gap and hold it until taken
   task automatic send_word(input req_type word, input bit pinned, input rsp_type want,
                            input bit steady);
      int gap;
      int pick;
      pick = $urandom_range(0, 19);
      if (steady || pick < 11)
         gap = 0;
      else if (pick < 18)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(8, 40);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_data     <= word;
      pinned_valid <= pinned;
      pinned_rsp   <= want;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // Track the register, predict each taken word and check each result word
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         active_code = ROT_NONE;
      end else begin
         if (rsp_valid) begin
            if (pending_rotations.size() == 0) begin
               $error("result word with no prediction waiting");
               mismatch_count++;
            end else begin
               want = pending_rotations.pop_front();
               if (rsp_data.x_out !== want.x_out) begin
                  $error("x_out: expected %0d, got %0d", want.x_out, rsp_data.x_out);
                  mismatch_count++;
               end
               if (rsp_data.y_out !== want.y_out) begin
                  $error("y_out: expected %0d, got %0d", want.y_out, rsp_data.y_out);
                  mismatch_count++;
               end
               if (rsp_data.z_out !== want.z_out) begin
                  $error("z_out: expected %0d, got %0d", want.z_out, rsp_data.z_out);
                  mismatch_count++;
               end
               if (rsp_data.clipped !== want.clipped) begin
                  $error("clipped: expected %0d, got %0d", want.clipped, rsp_data.clipped);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy)
            pending_rotations.push_back(pinned_valid ? pinned_rsp
                                                     : rotate_word(active_code, req_data));
         if (csr_we)
            active_code = csr_wdata;
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || rsp_valid || csr_we || (start && !busy))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= StallLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [5:0] code;
      bit         steady;
      int         n_items;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table, reloading the register when the code changes
      foreach (stim_rows[i]) begin
         if (stim_rows[i].code != loaded_code)
            load_orientation(stim_rows[i].code);
         send_word(stim_rows[i].word, stim_rows[i].pinned, stim_rows[i].want, 1'b0);
      end

      // Sweep every code, then a few random ones, with random words in each
      for (int p = 0; p < NumPhases; p++) begin
         code = (p < 64) ? 6'(p) : 6'($urandom_range(0, 63));
         load_orientation(code);
         steady  = ($urandom_range(0, 3) == 0);
         n_items = $urandom_range(8, 18);
         repeat (n_items)
            send_word('{random_component(), random_component(), random_component()},
                      1'b0, '0, steady);
      end

      start <= 1'b0;
      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && pending_rotations.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/sor_pkg.sv
hw/rtl/sor_mult.sv
hw/rtl/sor_finish.sv
hw/rtl/sensor_orientation_rotate_unit.sv
tb/tb_sensor_orientation_rotate_unit.sv
